FILE: hdl/cstp_pkg.sv
// Shared types and constants for the call stack time profiler.
`timescale 1ns / 1ps
`default_nettype none
package cstp_pkg;

   localparam int ADDR_FIELD_W      = 48;
   localparam int TIME_W            = 64;
   localparam int MAX_DEPTH_W       = 9;
   localparam int CSR_DATA_W        = 32;
   localparam int CSR_ADDR_W        = 3;
   localparam int OVF_W             = 32;
   localparam int STACK_DEPTH_DEF   = 256;
   localparam int ADDR_BITS_DEF     = 48;

   // register indexes
   localparam logic CSR_ENABLE      = 1'b0;
   localparam logic CSR_MAX_DEPTH   = 1'b1;

   // event kinds
   localparam logic MODE_ENTER      = 1'b0;
   localparam logic MODE_EXIT       = 1'b1;

   // add/subtract unit operations
   localparam logic OP_ADD          = 1'b0;
   localparam logic OP_SUB          = 1'b1;

   typedef struct packed {
      logic                    mode;
      logic [ADDR_FIELD_W-1:0] func_addr;
      logic [TIME_W-1:0]       timestamp;
   } req_type;

   typedef struct packed {
      logic [ADDR_FIELD_W-1:0] done_addr;
      logic [TIME_W-1:0]       total_time;
      logic [TIME_W-1:0]       self_time;
   } rsp_type;

   typedef struct packed {
      logic rd_en;     // registered read of one frame
      logic push_en;   // write a whole new frame
      logic child_en;  // update child time only
   } mem_ctl_type;

endpackage
`default_nettype wire

FILE: hdl/call_stack_time_profiler.sv
// Top level of the call stack time profiler: sequencer, CSRs and result register.
`timescale 1ns / 1ps
`default_nettype none
// Shadow call stack profiler. Each item is a function enter or exit event with an
// address and a timestamp, taken when start is high and busy is low. An enter
// (and any item while profiling is off, and an exit that consumes a pending
// overflow or finds the stack empty) is finished in its accept cycle; busy stays
// low. An exit that matches the top frame raises busy through the compare, self
// and parent states; every frame the downward scan passes over adds one more
// registered frame-memory read; busy holds off new items. The pace is set by the
// single read port of the frame memory and the one 64-bit add/subtract unit,
// which computes total time, self time and the parent's child-time update in
// turn. A matched exit produces one result, strobed by rsp_valid for one cycle,
// in the cycle busy falls; the receiver must take it then, it cannot stall.
// Frames are STACK_DEPTH deep; addresses are kept in ADDR_BITS bits. CSRs:
// 0 = profiling enable (reset 1), 4 = max depth (reset 256, clamped to
// STACK_DEPTH). Write them only while the block is idle.
module call_stack_time_profiler #(
   parameter int STACK_DEPTH = cstp_pkg::STACK_DEPTH_DEF,
   parameter int ADDR_BITS   = cstp_pkg::ADDR_BITS_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // event channel
   input  wire logic                            start,
   output logic                                 busy,
   input  wire cstp_pkg::req_type               req_data,
   // result channel
   output logic                                 rsp_valid,
   output cstp_pkg::rsp_type                    rsp_data,
   // APB CSR port
   input  wire logic                            psel,
   input  wire logic                            penable,
   input  wire logic                            pwrite,
   input  wire logic [cstp_pkg::CSR_ADDR_W-1:0] paddr,
   input  wire logic [cstp_pkg::CSR_DATA_W-1:0] pwdata,
   output logic      [cstp_pkg::CSR_DATA_W-1:0] prdata,
   output logic                                 pready
);
   import cstp_pkg::*;

   localparam int IW = $clog2(STACK_DEPTH);          // frame index bits
   localparam int DW = $clog2(STACK_DEPTH + 1);      // depth counter bits
   localparam int CW = (DW > MAX_DEPTH_W) ? DW : MAX_DEPTH_W;

   // sequencer states
   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_CMP    = 2'd1;   // compare frame, compute total
   localparam logic [1:0] S_SELF   = 2'd2;   // compute self time
   localparam logic [1:0] S_PARENT = 2'd3;   // update parent, pop, emit

   logic [1:0]             state_ff, state_in;
   logic                   enable_ff, enable_in;
   logic [MAX_DEPTH_W-1:0] max_depth_ff, max_depth_in;
   logic [DW-1:0]          depth_ff, depth_in;
   logic [OVF_W-1:0]       ovf_ff, ovf_in;
   logic [IW-1:0]          scan_ff, scan_in;
   logic [ADDR_BITS-1:0]   req_addr_ff, req_addr_in;
   logic [TIME_W-1:0]      req_time_ff, req_time_in;
   logic [TIME_W-1:0]      total_ff, total_in;
   logic [TIME_W-1:0]      child_ff, child_in;
   logic [TIME_W-1:0]      self_ff, self_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_data_ff, rsp_data_in;

   mem_ctl_type            mem_ctl;
   logic [IW-1:0]          mem_waddr, mem_raddr;
   logic [TIME_W-1:0]      mem_wr_child;
   logic [ADDR_BITS-1:0]   mem_rd_addr;
   logic [TIME_W-1:0]      mem_rd_entry, mem_rd_child;

   logic [TIME_W-1:0]      alu_a, alu_b, alu_sum;
   logic                   alu_op, alu_carry;

   logic                   accept, csr_write, can_push;
   logic [DW-1:0]          depth_m1;
   logic [IW-1:0]          scan_m1;
   logic [63:0]            in_addr_wide, out_addr_wide;

   // ---------------------------------------------------------------- CSRs
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   // only paddr[2] selects a register; low bits are ignored
   assign prdata    = (paddr[2] == CSR_MAX_DEPTH) ? CSR_DATA_W'(max_depth_ff)
                                                  : CSR_DATA_W'(enable_ff);

   always_comb begin
      enable_in    = enable_ff;
      max_depth_in = max_depth_ff;
      if (csr_write) begin
         case (paddr[2])
            CSR_ENABLE:    enable_in    = pwdata[0];
            CSR_MAX_DEPTH: max_depth_in = pwdata[MAX_DEPTH_W-1:0];
            default:       enable_in    = enable_ff;
         endcase
      end
   end

   // ---------------------------------------------------------------- datapath
   assign accept        = start && !busy;
   assign busy          = (state_ff != S_IDLE);
   assign in_addr_wide  = 64'(req_data.func_addr);
   assign out_addr_wide = 64'(req_addr_ff);
   assign depth_m1      = depth_ff - DW'(1);
   assign scan_m1       = scan_ff - IW'(1);
   // limit is max_depth clamped to the physical stack
   assign can_push      = (CW'(depth_ff) < CW'(max_depth_ff))
                       && (depth_ff < DW'(STACK_DEPTH));

   // shared unit operand select
   always_comb begin
      case (state_ff)
         S_CMP: begin
            alu_a  = req_time_ff;
            alu_b  = mem_rd_entry;
            alu_op = OP_SUB;
         end
         S_SELF: begin
            alu_a  = total_ff;
            alu_b  = child_ff;
            alu_op = OP_SUB;
         end
         default: begin
            alu_a  = mem_rd_child;   // parent's child time
            alu_b  = total_ff;
            alu_op = OP_ADD;
         end
      endcase
   end

   cstp_addsub u_alu (
      .a     (alu_a),
      .b     (alu_b),
      .op    (alu_op),
      .sum   (alu_sum),
      .carry (alu_carry)
   );

   cstp_frame_mem #(
      .STACK_DEPTH (STACK_DEPTH),
      .ADDR_BITS   (ADDR_BITS)
   ) u_frames (
      .clock    (clock),
      .ctl      (mem_ctl),
      .waddr    (mem_waddr),
      .wr_addr  (req_addr_in),
      .wr_entry (req_data.timestamp),
      .wr_child (mem_wr_child),
      .raddr    (mem_raddr),
      .rd_addr  (mem_rd_addr),
      .rd_entry (mem_rd_entry),
      .rd_child (mem_rd_child)
   );

   // ---------------------------------------------------------------- sequencer
   always_comb begin
      state_in     = state_ff;
      depth_in     = depth_ff;
      ovf_in       = ovf_ff;
      scan_in      = scan_ff;
      req_addr_in  = req_addr_ff;
      req_time_in  = req_time_ff;
      total_in     = total_ff;
      child_in     = child_ff;
      self_in      = self_ff;
      rsp_valid_in = 1'b0;
      rsp_data_in  = rsp_data_ff;
      mem_ctl      = '0;
      mem_waddr    = scan_m1;
      mem_raddr    = scan_m1;
      mem_wr_child = alu_sum;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               req_addr_in = in_addr_wide[ADDR_BITS-1:0];
               req_time_in = req_data.timestamp;
            end
            if (accept && enable_ff) begin
               if (req_data.mode == MODE_ENTER) begin
                  if (can_push) begin
                     mem_ctl.push_en = 1'b1;
                     mem_waddr       = depth_ff[IW-1:0];
                     mem_wr_child    = '0;
                     depth_in        = depth_ff + DW'(1);
                  end else if (ovf_ff != {OVF_W{1'b1}}) begin
                     ovf_in = ovf_ff + OVF_W'(1);
                  end
               end else if (ovf_ff != '0) begin
                  // exit absorbed by a frame that was never pushed
                  ovf_in = ovf_ff - OVF_W'(1);
               end else if (depth_ff != '0) begin
                  mem_ctl.rd_en = 1'b1;
                  mem_raddr     = depth_m1[IW-1:0];
                  scan_in       = depth_m1[IW-1:0];
                  state_in      = S_CMP;
               end
            end
         end
         S_CMP: begin
            // next read is the frame below: parent on a hit, next candidate on a miss
            mem_ctl.rd_en = (scan_ff != '0);
            if (mem_rd_addr == req_addr_ff) begin
               total_in = alu_carry ? alu_sum : '0;
               child_in = mem_rd_child;
               state_in = S_SELF;
            end else if (scan_ff != '0) begin
               scan_in = scan_m1;
            end else begin
               state_in = S_IDLE;    // no matching frame
            end
         end
         S_SELF: begin
            self_in  = alu_carry ? alu_sum : '0;
            state_in = S_PARENT;
         end
         S_PARENT: begin
            mem_ctl.child_en       = (scan_ff != '0);
            depth_in               = DW'(scan_ff);
            rsp_valid_in           = 1'b1;
            rsp_data_in.done_addr  = out_addr_wide[ADDR_FIELD_W-1:0];
            rsp_data_in.total_time = total_ff;
            rsp_data_in.self_time  = self_ff;
            state_in               = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         enable_ff    <= 1'b1;
         max_depth_ff <= MAX_DEPTH_W'(256);
         depth_ff     <= '0;
         ovf_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         enable_ff    <= enable_in;
         max_depth_ff <= max_depth_in;
         depth_ff     <= depth_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_ff     <= scan_in;
      req_addr_ff <= req_addr_in;
      req_time_ff <= req_time_in;
      total_ff    <= total_in;
      child_ff    <= child_in;
      self_ff     <= self_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // ---------------------------------------------------------------- checks
   a_rsp_from_parent: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $past(state_ff == S_PARENT))
      else $error("result strobe without a completed pop");

   a_depth_bound: assert property (@(posedge clock) disable iff (reset)
      depth_ff <= DW'(STACK_DEPTH))
      else $error("stack depth beyond storage");

   a_scan_in_stack: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CMP) |-> (DW'(scan_ff) < depth_ff))
      else $error("scan index outside live frames");

   a_busy_on_exit: assert property (@(posedge clock) disable iff (reset)
      $rose(busy) |-> $past(req_data.mode == MODE_EXIT && enable_ff && ovf_ff == '0))
      else $error("sequencer started without a scanning exit");

endmodule
`default_nettype wire

FILE: hdl/cstp_addsub.sv
// Shared 64-bit add/subtract unit with carry out.
`timescale 1ns / 1ps
`default_nettype none
module cstp_addsub (
   input  wire logic [cstp_pkg::TIME_W-1:0] a,
   input  wire logic [cstp_pkg::TIME_W-1:0] b,
   input  wire logic                        op,
   output logic      [cstp_pkg::TIME_W-1:0] sum,
   output logic                             carry
);
   import cstp_pkg::*;

   logic [TIME_W:0] full;

   // carry set on subtract means a >= b
   assign full  = {1'b0, a} + {1'b0, b ^ {TIME_W{op == OP_SUB}}} + (TIME_W+1)'(op == OP_SUB);
   assign sum   = full[TIME_W-1:0];
   assign carry = full[TIME_W];

endmodule
`default_nettype wire

FILE: hdl/cstp_frame_mem.sv
// Frame store: address, entry time and child time per stack slot.
`timescale 1ns / 1ps
`default_nettype none
module cstp_frame_mem #(
   parameter int STACK_DEPTH = cstp_pkg::STACK_DEPTH_DEF,
   parameter int ADDR_BITS   = cstp_pkg::ADDR_BITS_DEF,
   localparam int IW         = $clog2(STACK_DEPTH)
) (
   input  wire logic                        clock,
   input  wire cstp_pkg::mem_ctl_type       ctl,
   input  wire logic [IW-1:0]               waddr,
   input  wire logic [ADDR_BITS-1:0]        wr_addr,
   input  wire logic [cstp_pkg::TIME_W-1:0] wr_entry,
   input  wire logic [cstp_pkg::TIME_W-1:0] wr_child,
   input  wire logic [IW-1:0]               raddr,
   output logic      [ADDR_BITS-1:0]        rd_addr,
   output logic      [cstp_pkg::TIME_W-1:0] rd_entry,
   output logic      [cstp_pkg::TIME_W-1:0] rd_child
);
   import cstp_pkg::*;

   logic [ADDR_BITS-1:0] addr_mem  [STACK_DEPTH];
   logic [TIME_W-1:0]    entry_mem [STACK_DEPTH];
   logic [TIME_W-1:0]    child_mem [STACK_DEPTH];

   always_ff @(posedge clock) begin
      if (ctl.push_en) begin
         addr_mem[waddr]  <= wr_addr;
         entry_mem[waddr] <= wr_entry;
      end
      if (ctl.push_en || ctl.child_en) begin
         child_mem[waddr] <= wr_child;
      end
   end

   // read data holds until the next read
   always_ff @(posedge clock) begin
      if (ctl.rd_en) begin
         rd_addr  <= addr_mem[raddr];
         rd_entry <= entry_mem[raddr];
         rd_child <= child_mem[raddr];
      end
   end

endmodule
`default_nettype wire

FILE: sim/stack_profile_checker.sv
// Shadow call stack predictor and return-record checker for the call stack time profiler.
`timescale 1ns / 1ps
module stack_profile_checker (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            start,
   input  wire logic                            busy,
   input  cstp_pkg::req_type                    req_data,
   input  wire logic                            rsp_valid,
   input  cstp_pkg::rsp_type                    rsp_data,
   input  wire logic                            psel,
   input  wire logic                            penable,
   input  wire logic                            pwrite,
   input  wire logic [cstp_pkg::CSR_ADDR_W-1:0] paddr,
   input  wire logic [cstp_pkg::CSR_DATA_W-1:0] pwdata,
   input  wire logic                            pready,
   output int                                   fail_count,
   output int                                   pending_count,
   output int                                   returns_checked
);
   import cstp_pkg::*;

   localparam logic [CSR_ADDR_W-1:0] ENABLE_ADDR = {CSR_ENABLE, 2'b00};
   localparam logic [CSR_ADDR_W-1:0] DEPTH_ADDR  = {CSR_MAX_DEPTH, 2'b00};

   logic [ADDR_FIELD_W-1:0] frame_fn    [STACK_DEPTH_DEF];
   logic [TIME_W-1:0]       frame_start [STACK_DEPTH_DEF];
   logic [TIME_W-1:0]       frame_kids  [STACK_DEPTH_DEF];
   int unsigned             open_frames;
   logic [OVF_W-1:0]        lost_enters;
   logic                    tracing_on;
   logic [MAX_DEPTH_W-1:0]  depth_cap;
   rsp_type                 due_returns [$];

   initial begin
      fail_count      = 0;
      returns_checked = 0;
      pending_count   = 0;
   end

   function automatic int unsigned frame_limit();
      return (depth_cap > STACK_DEPTH_DEF) ? STACK_DEPTH_DEF : depth_cap;
   endfunction

   function automatic void account_event(req_type ev);
      int unsigned       slot;
      bit                hit;
      logic [TIME_W-1:0] total;
      logic [TIME_W-1:0] own;
      rsp_type           ret;
      if (!tracing_on) return;
      if (ev.mode == MODE_ENTER) begin
         if (open_frames < frame_limit()) begin
            frame_fn[open_frames]    = ev.func_addr;
            frame_start[open_frames] = ev.timestamp;
            frame_kids[open_frames]  = '0;
            open_frames++;
         end else if (lost_enters != '1) begin
            lost_enters++;
         end
         return;
      end
      // exit pays back a dropped enter first
      if (lost_enters != '0) begin
         lost_enters--;
         return;
      end
      slot = open_frames;
      hit  = 1'b0;
      while (slot > 0 && !hit) begin
         slot--;
         hit = (frame_fn[slot] == ev.func_addr);
      end
      if (!hit) return;
      total = (ev.timestamp > frame_start[slot]) ? ev.timestamp - frame_start[slot] : '0;
      own   = (total > frame_kids[slot]) ? total - frame_kids[slot] : '0;
      if (slot > 0) frame_kids[slot-1] += total;
      open_frames = slot;
      ret.done_addr  = ev.func_addr;
      ret.total_time = total;
      ret.self_time  = own;
      due_returns.push_back(ret);
   endfunction

   task automatic compare_return(rsp_type got);
      rsp_type want;
      if (due_returns.size() == 0) begin
         $display("%0t: return with none due: expected nothing, actual addr %h total %h self %h",
                  $time, got.done_addr, got.total_time, got.self_time);
         fail_count++;
         return;
      end
      want = due_returns.pop_front();
      returns_checked++;
      if (got.done_addr !== want.done_addr) begin
         $display("%0t: done_addr expected %h actual %h", $time, want.done_addr, got.done_addr);
         fail_count++;
      end
      if (got.total_time !== want.total_time) begin
         $display("%0t: total_time expected %h actual %h", $time, want.total_time,
                  got.total_time);
         fail_count++;
      end
      if (got.self_time !== want.self_time) begin
         $display("%0t: self_time expected %h actual %h", $time, want.self_time, got.self_time);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         open_frames = 0;
         lost_enters = '0;
         tracing_on  = 1'b1;
         depth_cap   = MAX_DEPTH_W'(STACK_DEPTH_DEF);
         due_returns.delete();
      end else begin
         if (psel && penable && pwrite && pready) begin
            if (paddr == ENABLE_ADDR) tracing_on = pwdata[0];
            else if (paddr == DEPTH_ADDR) depth_cap = pwdata[MAX_DEPTH_W-1:0];
         end
         if (start && !busy) account_event(req_data);
         if (rsp_valid) compare_return(rsp_data);
      end
      pending_count <= due_returns.size();
   end

endmodule

FILE: sim/testbench.sv
// Stimulus, register setup and verdict for the call stack time profiler.
`timescale 1ns / 1ps
module testbench;
   import cstp_pkg::*;

   // long enough for an exit that scans the whole stack and misses
   localparam int SETTLE_CYCLES = STACK_DEPTH_DEF + 16;
   localparam int DRAIN_LIMIT   = 20000;
   localparam int IDLE_PCT      = 30;

   logic                    clock;
   logic                    reset;
   logic                    start;
   logic                    busy;
   req_type                 req_data;
   logic                    rsp_valid;
   rsp_type                 rsp_data;
   logic                    psel;
   logic                    penable;
   logic                    pwrite;
   logic [CSR_ADDR_W-1:0]   paddr;
   logic [CSR_DATA_W-1:0]   pwdata;
   logic [CSR_DATA_W-1:0]   prdata;
   logic                    pready;

   int                      fail_count;
   int                      pending_count;
   int                      returns_checked;

   // stimulus-side view of the call stack; only steers which exits are sent
   logic [ADDR_FIELD_W-1:0] open_calls [$];
   // a few addresses reused so recursion puts duplicates on the stack
   logic [ADDR_FIELD_W-1:0] call_pool [8];
   logic [TIME_W-1:0]       event_clock;
   bit                      no_gaps;
   int                      items_sent;
   int                      csr_writes;

   call_stack_time_profiler DUT (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   stack_profile_checker u_stack_check (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_data        (req_data),
      .rsp_valid       (rsp_valid),
      .rsp_data        (rsp_data),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .pready          (pready),
      .fail_count      (fail_count),
      .pending_count   (pending_count),
      .returns_checked (returns_checked)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // hard stop in case the block hangs
   initial begin
      #2_500_000;
      $display("[FAIL] regression broken");
      $finish;
   end

   function automatic logic [ADDR_FIELD_W-1:0] random_addr();
      logic [63:0] r;
      r = {$urandom, $urandom};
      return r[ADDR_FIELD_W-1:0];
   endfunction

   function automatic logic [TIME_W-1:0] random_time();
      return {$urandom, $urandom};
   endfunction

   // start held low; the data lines carry junk meanwhile
   task automatic idle(int n);
      req_type junk;
      repeat (n) begin
         junk.mode      = $urandom_range(0, 1);
         junk.func_addr = random_addr();
         junk.timestamp = random_time();
         @(negedge clock);
         start    <= 1'b0;
         req_data <= junk;
         @(posedge clock);
      end
   endtask

   // present one item and hold it until the edge that takes it
   task automatic send_item(req_type ev);
      if (!no_gaps && $urandom_range(0, 99) < IDLE_PCT) idle($urandom_range(1, 4));
      @(negedge clock);
      start    <= 1'b1;
      req_data <= ev;
      do @(posedge clock); while (busy);
      items_sent++;
   endtask

   task automatic call_in(logic [ADDR_FIELD_W-1:0] fn, logic [TIME_W-1:0] ts);
      req_type ev;
      ev.mode      = MODE_ENTER;
      ev.func_addr = fn;
      ev.timestamp = ts;
      send_item(ev);
   endtask

   task automatic call_out(logic [ADDR_FIELD_W-1:0] fn, logic [TIME_W-1:0] ts);
      req_type ev;
      ev.mode      = MODE_EXIT;
      ev.func_addr = fn;
      ev.timestamp = ts;
      send_item(ev);
   endtask

   // wait for every due return, then for the longest scan to finish
   task automatic settle();
      @(negedge clock);
      start <= 1'b0;
      for (int w = 0; w < DRAIN_LIMIT && pending_count != 0; w++) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(logic idx, logic [CSR_DATA_W-1:0] value);
      settle();
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(negedge clock);
      penable <= 1'b1;
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      csr_writes++;
   endtask

   // Mostly well-formed call/return traffic: enters up to a target depth,
   // exits that return the innermost call or unwind several at once, a few
   // out-of-order timestamps, plus fully random junk items.
   task automatic random_phase(int n, int target, int enter_pct, int noise_pct);
      req_type ev;
      int      k;
      for (int i = 0; i < n; i++) begin
         event_clock += $urandom_range(0, 1500);
         ev.timestamp = event_clock;
         if ($urandom_range(0, 99) < 5) ev.timestamp = random_time();
         if ($urandom_range(0, 99) < noise_pct) begin
            ev.mode      = $urandom_range(0, 1);
            ev.func_addr = random_addr();
            ev.timestamp = random_time();
         end else if (open_calls.size() == 0 ||
                      (open_calls.size() < target && $urandom_range(0, 99) < enter_pct)) begin
            ev.mode      = MODE_ENTER;
            ev.func_addr = ($urandom_range(0, 99) < 30) ? call_pool[$urandom_range(0, 7)]
                                                        : random_addr();
            open_calls.push_back(ev.func_addr);
         end else begin
            ev.mode = MODE_EXIT;
            k = open_calls.size() - 1;
            // sometimes return from an outer call, skipping inner frames
            if ($urandom_range(0, 99) < 15) k = $urandom_range(0, open_calls.size() - 1);
            ev.func_addr = open_calls[k];
            while (open_calls.size() > k) void'(open_calls.pop_back());
         end
         send_item(ev);
      end
   endtask

   initial begin
      reset       = 1'b1;
      start       = 1'b0;
      req_data    = '0;
      psel        = 1'b0;
      penable     = 1'b0;
      pwrite      = 1'b0;
      paddr       = '0;
      pwdata      = '0;
      no_gaps     = 1'b0;
      items_sent  = 0;
      csr_writes  = 0;
      event_clock = 64'd1000;
      for (int i = 0; i < 8; i++) call_pool[i] = random_addr();
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      repeat (4) @(posedge clock);

      // directed: field extremes, clamping, child-time wrap, recursion,
      // unmatched exit and exits on an empty stack (reset settings)
      call_in('0, '0);
      call_in('1, 64'd100);
      call_out('1, 64'd50);                  // exit earlier than entry: total clamps
      call_in(48'd5, 64'd200);
      call_out(48'd5, '1);                    // huge total lands in parent
      call_in(48'd6, '0);
      call_out(48'd6, '1);                    // parent child time wraps
      call_out('0, 64'd300);
      call_out('0, 64'd310);                  // empty stack
      call_in(48'd7, 64'd1000);
      call_in(48'd8, 64'd1001);
      call_in(48'd7, 64'd1002);               // recursive entry
      call_in(48'd9, 64'd1003);
      call_out(48'd123, 64'd1004);            // no frame matches
      call_out(48'd7, 64'd1010);              // innermost 7, pops 9 with it
      call_out(48'd7, 64'd1020);              // outer 7, pops 8 with it
      call_out({24{2'b10}}, {32{2'b01}});

      // tiny stacks: one frame kept, then none at all
      csr_write(CSR_MAX_DEPTH, 32'd1);
      random_phase(150, 3, 50, 8);
      csr_write(CSR_MAX_DEPTH, 32'd0);
      random_phase(60, 3, 50, 8);

      // tracing off: everything ignored, stack left untouched
      csr_write(CSR_ENABLE, 32'd0);
      random_phase(60, 3, 50, 100);
      csr_write(CSR_ENABLE, 32'd1);

      // limit hit regularly, then lowered under the current depth
      csr_write(CSR_MAX_DEPTH, 32'd6);
      random_phase(200, 8, 50, 8);
      random_phase(4, 100, 100, 0);
      csr_write(CSR_MAX_DEPTH, 32'd2);
      random_phase(80, 5, 50, 8);

      // oversized limit clamps to the full stack; fill it past the top
      csr_write(CSR_MAX_DEPTH, 32'd511);
      random_phase(262, 262, 100, 0);
      random_phase(100, 262, 50, 8);

      // default depth, first back to back, then with gaps again
      csr_write(CSR_MAX_DEPTH, 32'd256);
      no_gaps = 1'b1;
      random_phase(300, 12, 50, 8);
      no_gaps = 1'b0;
      random_phase(200, 12, 50, 8);

      settle();
      $display("Sent %0d events over %0d register writes: depth caps 0 to 511, tracing off/on.",
               items_sent, csr_writes);
      $display("Compared %0d returned frames; %0d still outstanding.",
               returns_checked, pending_count);
      if (fail_count == 0 && pending_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

FILE: files.f
hdl/cstp_pkg.sv
hdl/cstp_addsub.sv
hdl/cstp_frame_mem.sv
hdl/call_stack_time_profiler.sv
sim/stack_profile_checker.sv
sim/testbench.sv
